/* rtl/core/salpd_pkg.sv */
// Shared types and constants of the shake-arm long-press-disarm detector.
package salpd_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int THR_W       = 12;
  localparam int HITS_W      = 8;
  localparam int WIN_W       = 16;
  localparam int HOLD_W      = 16;
  localparam int POLL_W      = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_DELTA_THRESHOLD  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HITS_NEEDED      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MS        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_MS          = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL_MS = 3'd4;

  localparam logic [THR_W-1:0]  RST_DELTA_THRESHOLD  = 12'd512;
  localparam logic [HITS_W-1:0] RST_HITS_NEEDED      = 8'd8;
  localparam logic [WIN_W-1:0]  RST_WINDOW_MS        = 16'd1400;
  localparam logic [HOLD_W-1:0] RST_HOLD_MS          = 16'd4000;
  localparam logic [POLL_W-1:0] RST_POLL_INTERVAL_MS = 10'd100;

  localparam logic [HITS_W-1:0] HIT_MAX = 8'd255;

  localparam logic [1:0] REQ_ACCEL = 2'd0;
  localparam logic [1:0] REQ_TOUCH = 2'd1;
  localparam logic [1:0] REQ_ARM   = 2'd2;

  typedef struct packed {
    logic [THR_W-1:0]  delta_threshold;
    logic [HITS_W-1:0] hits_needed;
    logic [WIN_W-1:0]  window_ms;
    logic [HOLD_W-1:0] hold_ms;
    logic [POLL_W-1:0] poll_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic armed;
    logic entered;
    logic exited;
  } result_t;

endpackage

/* rtl/core/salpd_if.sv */
// Valid/ready channel interfaces for the request and result streams.
interface salpd_in_if #(
  parameter int TIME_WIDTH   = 32,
  parameter int SAMPLE_WIDTH = 12
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic [TIME_WIDTH-1:0]   now_ms;
  logic [SAMPLE_WIDTH-1:0] delta_g;
  logic                    touch_down;
  logic                    arm_on;

  modport source (output valid, req_type, now_ms, delta_g, touch_down, arm_on,
                  input ready);
  modport sink (input valid, req_type, now_ms, delta_g, touch_down, arm_on,
                output ready);
endinterface

interface salpd_out_if;
  logic valid;
  logic ready;
  logic active;
  logic armed;
  logic entered;
  logic exited;

  modport source (output valid, active, armed, entered, exited, input ready);
  modport sink (input valid, active, armed, entered, exited, output ready);
endinterface

/* rtl/core/salpd_cfg.sv */
// Configuration register file with its write decoder.
module salpd_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [salpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [salpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output salpd_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delta_threshold  <= salpd_pkg::RST_DELTA_THRESHOLD;
      cfg.hits_needed      <= salpd_pkg::RST_HITS_NEEDED;
      cfg.window_ms        <= salpd_pkg::RST_WINDOW_MS;
      cfg.hold_ms          <= salpd_pkg::RST_HOLD_MS;
      cfg.poll_interval_ms <= salpd_pkg::RST_POLL_INTERVAL_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        salpd_pkg::REG_DELTA_THRESHOLD: begin
          cfg.delta_threshold <= cfg_data[salpd_pkg::THR_W-1:0];
        end
        salpd_pkg::REG_HITS_NEEDED: begin
          cfg.hits_needed <= cfg_data[salpd_pkg::HITS_W-1:0];
        end
        salpd_pkg::REG_WINDOW_MS: begin
          cfg.window_ms <= cfg_data[salpd_pkg::WIN_W-1:0];
        end
        salpd_pkg::REG_HOLD_MS: begin
          cfg.hold_ms <= cfg_data[salpd_pkg::HOLD_W-1:0];
        end
        salpd_pkg::REG_POLL_INTERVAL_MS: begin
          cfg.poll_interval_ms <= cfg_data[salpd_pkg::POLL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/salpd_core.sv */
// Detector state registers and the per-beat update logic.
module salpd_core #(
  parameter int TIME_WIDTH   = 32,
  parameter int SAMPLE_WIDTH = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  salpd_pkg::cfg_t         cfg,
  input  logic                    step,
  input  logic [1:0]              req_type,
  input  logic [TIME_WIDTH-1:0]   now_ms,
  input  logic [SAMPLE_WIDTH-1:0] delta_g,
  input  logic                    touch_down,
  input  logic                    arm_on,
  output salpd_pkg::result_t      result
);

  localparam int CMP_W = (SAMPLE_WIDTH > salpd_pkg::THR_W) ? SAMPLE_WIDTH
                                                           : salpd_pkg::THR_W;

  logic                          armed_flag, armed_flag_next;
  logic                          active_flag, active_flag_next;
  logic [salpd_pkg::HITS_W-1:0]  hit_count, hit_count_next;
  logic [TIME_WIDTH-1:0]         window_start, window_start_next;
  logic [TIME_WIDTH-1:0]         press_start, press_start_next;
  logic                          pressing, pressing_next;
  logic [TIME_WIDTH-1:0]         last_poll, last_poll_next;

  logic [TIME_WIDTH-1:0]         win_elapsed, poll_elapsed, press_elapsed;
  logic [salpd_pkg::HITS_W-1:0]  hit_base, hit_inc;
  logic                          is_hit;
  logic                          entered, exited;

  assign win_elapsed   = now_ms - window_start;
  assign poll_elapsed  = now_ms - last_poll;
  assign press_elapsed = now_ms - press_start;
  assign is_hit = CMP_W'(delta_g) >= CMP_W'(cfg.delta_threshold);

  // An expired window restarts before the current sample is counted.
  assign hit_base = (win_elapsed > TIME_WIDTH'(cfg.window_ms)) ? '0 : hit_count;
  assign hit_inc  = (hit_base != salpd_pkg::HIT_MAX) ? hit_base + 8'd1 : hit_base;

  always_comb begin
    armed_flag_next   = armed_flag;
    active_flag_next  = active_flag;
    hit_count_next    = hit_count;
    window_start_next = window_start;
    press_start_next  = press_start;
    pressing_next     = pressing;
    last_poll_next    = last_poll;
    entered           = 1'b0;
    exited            = 1'b0;
    unique case (req_type)
      salpd_pkg::REQ_ACCEL: begin
        if (armed_flag && !active_flag) begin
          if (win_elapsed > TIME_WIDTH'(cfg.window_ms)) begin
            window_start_next = now_ms;
          end
          hit_count_next = is_hit ? hit_inc : hit_base;
          if (is_hit && (hit_inc >= cfg.hits_needed)) begin
            active_flag_next = 1'b1;
            entered          = 1'b1;
          end
        end
      end
      salpd_pkg::REQ_TOUCH: begin
        if (!active_flag) begin
          pressing_next = 1'b0;
        end else if (poll_elapsed >= TIME_WIDTH'(cfg.poll_interval_ms)) begin
          last_poll_next = now_ms;
          if (touch_down) begin
            if (!pressing) begin
              pressing_next    = 1'b1;
              press_start_next = now_ms;
            end else if (press_elapsed >= TIME_WIDTH'(cfg.hold_ms)) begin
              pressing_next    = 1'b0;
              active_flag_next = 1'b0;
              exited           = 1'b1;
            end
          end else begin
            pressing_next = 1'b0;
          end
        end
      end
      salpd_pkg::REQ_ARM: begin
        armed_flag_next = arm_on;
        if (!arm_on) begin
          active_flag_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.active  = active_flag_next;
  assign result.armed   = armed_flag_next;
  assign result.entered = entered;
  assign result.exited  = exited;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag   <= 1'b0;
      active_flag  <= 1'b0;
      hit_count    <= '0;
      window_start <= '0;
      press_start  <= '0;
      pressing     <= 1'b0;
      last_poll    <= '0;
    end else if (step) begin
      armed_flag   <= armed_flag_next;
      active_flag  <= active_flag_next;
      hit_count    <= hit_count_next;
      window_start <= window_start_next;
      press_start  <= press_start_next;
      pressing     <= pressing_next;
      last_poll    <= last_poll_next;
    end
  end

endmodule

/* rtl/core/shake_arm_long_press_disarm.sv */
// Duress gesture detector: shake to enter the active state, long press to leave it.
//
// Requests arrive on in_ch as valid/ready beats: an accelerometer delta sample,
// a touch poll or an arm command, each with a millisecond timestamp. Every
// request beat produces exactly one result beat on out_ch carrying the active
// and armed flags after the request and the entered and exited pulses.
// A request's result appears in the cycle after its acceptance. Throughput
// is one request per cycle while the receiver does not stall; the detector
// state updates in the cycle of acceptance, and the result sits in a single
// output register. in_ch.ready is high whenever that register is empty or
// is being emptied, so a stalled receiver holds the result steady and pauses
// the request side only while the register is full.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user is to write them only while the block is idle, which the block does not
// enforce; unknown indexes are ignored. Synchronous reset clears all detector
// state, empties the output register and restores the configuration defaults
// (2.0 g threshold, 8 hits, 1400 ms window, 4000 ms hold, 100 ms poll interval).
module shake_arm_long_press_disarm #(
  parameter int TIME_WIDTH   = 32,
  parameter int SAMPLE_WIDTH = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  salpd_in_if.sink                          in_ch,
  salpd_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [salpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [salpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  salpd_pkg::cfg_t    cfg;
  salpd_pkg::result_t result;
  salpd_pkg::result_t out_reg;
  logic               out_valid;
  logic               in_accept;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  salpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  salpd_core #(
    .TIME_WIDTH   (TIME_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (in_accept),
    .req_type   (in_ch.req_type),
    .now_ms     (in_ch.now_ms),
    .delta_g    (in_ch.delta_g),
    .touch_down (in_ch.touch_down),
    .arm_on     (in_ch.arm_on),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_reg <= result;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.active  = out_reg.active;
  assign out_ch.armed   = out_reg.armed;
  assign out_ch.entered = out_reg.entered;
  assign out_ch.exited  = out_reg.exited;

endmodule

/* rtl/core/salpd_checker.sv */
// Port-level assertions for the detector and their bind to the top level.
module salpd_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_active,
  input logic out_armed,
  input logic out_entered,
  input logic out_exited
);

  // Entry can only happen while armed, and leaves the block active.
  a_entered_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_entered) |-> (out_active && out_armed))
    else $error("entered pulse without active and armed");

  a_pulses_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_entered && out_exited))
    else $error("entered and exited on the same beat");

  a_exited_inactive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_exited) |-> !out_active)
    else $error("exited pulse while still active");

  // An empty output register must never hold off the request side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request side stalled with empty output");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_active) &&
      $stable(out_armed) && $stable(out_entered) && $stable(out_exited)))
    else $error("result beat changed while stalled");

endmodule

bind shake_arm_long_press_disarm salpd_checker u_salpd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_active  (out_ch.active),
  .out_armed   (out_ch.armed),
  .out_entered (out_ch.entered),
  .out_exited  (out_ch.exited)
);
